@@ design/btp_pkg.sv @@
`default_nettype none
// ---------------------------------------------------------------------------
// btp_pkg: shared types and constants for the token pool
// Request codes, the command/status bundles between the controller and the
// datapath, and the find-first-set helper used by the allocation scan.
// ---------------------------------------------------------------------------
package btp_pkg;

	// request codes
	localparam logic [1:0] REQ_BIRTH = 2'd0;
	localparam logic [1:0] REQ_KILL  = 2'd1;
	localparam logic [1:0] REQ_QUERY = 2'd2;

	// bitmap word geometry
	localparam int WORD_W = 64;
	localparam int BIT_W  = 6;

	// field widths of the channels
	localparam int REQ_W     = 2;
	localparam int TOKIN_W   = 12;
	localparam int TOKOUT_W  = 10;

	// controller -> datapath
	typedef struct packed {
		logic clear;   // write one zero word of the clearing pass
		logic load;    // capture a transfer and start the first word read
		logic eval;    // word data is valid: decide, write back, or step
		logic push;    // move the finished result into the output register
	} btp_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic clr_last; // clearing pass is on its last word
		logic done;     // current evaluation finishes the request
		logic out_busy; // output register holds a result that is not taken
	} btp_sts_t;

	typedef struct packed {
		logic             found;
		logic [BIT_W-1:0] idx;
	} ffs_t;

	// lowest set bit of a 64-bit word, as byte flags and a byte pick
	function automatic ffs_t ffs64(input logic [WORD_W-1:0] v);
		ffs_t       r;
		logic [7:0] any;
		logic [2:0] sub [8];
		int         g;
		int         b;
		for (g = 0; g < 8; g++) begin
			any[g] = |v[g*8 +: 8];
			sub[g] = 3'd0;
			for (b = 7; b >= 0; b--) begin
				if (v[g*8 + b]) begin
					sub[g] = 3'(b);
				end
			end
		end
		r.found = |any;
		r.idx   = '0;
		for (g = 7; g >= 0; g--) begin
			if (any[g]) begin
				r.idx = {3'(g), sub[g]};
			end
		end
		return r;
	endfunction

endpackage
`default_nettype wire

@@ design/btp_req_if.sv @@
`default_nettype none
// ---------------------------------------------------------------------------
// btp_req_if: request channel
// Valid/ready channel carrying a request code and a token.
// ---------------------------------------------------------------------------
interface btp_req_if;
	logic                            valid;
	logic                            ready;
	logic [btp_pkg::REQ_W-1:0]       req_type;
	logic [btp_pkg::TOKIN_W-1:0]     token_in;

	modport source (output valid, output req_type, output token_in, input ready);
	modport sink   (input valid, input req_type, input token_in, output ready);
endinterface
`default_nettype wire

@@ design/btp_rsp_if.sv @@
`default_nettype none
// ---------------------------------------------------------------------------
// btp_rsp_if: response channel
// Valid/ready channel carrying the allocated token and the liveness flag.
// ---------------------------------------------------------------------------
interface btp_rsp_if;
	logic                            valid;
	logic                            ready;
	logic [btp_pkg::TOKOUT_W-1:0]    token_out;
	logic                            is_live;

	modport source (output valid, output token_out, output is_live, input ready);
	modport sink   (input valid, input token_out, input is_live, output ready);
endinterface
`default_nettype wire

@@ design/btp_ram.sv @@
`default_nettype none
// ---------------------------------------------------------------------------
// btp_ram: generic single-write, single-read RAM
// One write port and one read port, read data registered.
// ---------------------------------------------------------------------------
module btp_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 16
) (
	input  wire logic                                      clk,
	input  wire logic                                      we,
	input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  wire logic [WIDTH-1:0]                          wdata,
	input  wire logic                                      re,
	input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic      [WIDTH-1:0]                          rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write port and registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule
`default_nettype wire

@@ design/btp_ctrl.sv @@
`default_nettype none
// ---------------------------------------------------------------------------
// btp_ctrl: token pool sequencer
// Runs the clearing pass after reset, takes one request at a time, steps
// the bitmap scan and hands the result to the output register.
// ---------------------------------------------------------------------------
module btp_ctrl (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              req_valid,
	output logic                   req_ready,
	input  wire btp_pkg::btp_sts_t sts,
	output btp_pkg::btp_cmd_t      cmd
);

	typedef enum logic [1:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_ACCESS,
		ST_FINISH
	} state_t;

	state_t state_q;

	assign req_ready = (state_q == ST_IDLE);

	// commands follow the state and the datapath status
	always_comb begin
		cmd       = '0;
		cmd.clear = (state_q == ST_CLEAR);
		cmd.load  = (state_q == ST_IDLE) && req_valid;
		cmd.eval  = (state_q == ST_ACCESS);
		cmd.push  = (state_q == ST_FINISH) && !sts.out_busy;
	end

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			case (state_q)
				ST_CLEAR: begin
					if (sts.clr_last) state_q <= ST_IDLE;
				end
				ST_IDLE: begin
					if (req_valid) state_q <= ST_ACCESS;
				end
				ST_ACCESS: begin
					if (sts.done) state_q <= ST_FINISH;
				end
				ST_FINISH: begin
					if (!sts.out_busy) state_q <= ST_IDLE;
				end
				default: state_q <= ST_CLEAR;
			endcase
		end
	end

endmodule
`default_nettype wire

@@ design/btp_dpath.sv @@
`default_nettype none
// ---------------------------------------------------------------------------
// btp_dpath: token pool datapath
// Bitmap RAM, next-fit pointer, word scan with find-first-free, kill and
// query bit access, and the output register.
// ---------------------------------------------------------------------------
module btp_dpath #(
	parameter int TOKEN_MAX = 1023,
	parameter int TOKEN_MIN = 16
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire btp_pkg::btp_cmd_t               cmd,
	output btp_pkg::btp_sts_t                    sts,
	input  wire logic [btp_pkg::REQ_W-1:0]       req_type,
	input  wire logic [btp_pkg::TOKIN_W-1:0]     token_in,
	output logic                                 rsp_valid,
	input  wire logic                            rsp_ready,
	output logic      [btp_pkg::TOKOUT_W-1:0]    token_out,
	output logic                                 is_live
);

	localparam int POOL_WORDS = (TOKEN_MAX >> 6) + 1;
	localparam int AW         = (POOL_WORDS > 1) ? $clog2(POOL_WORDS) : 1;
	localparam int TW         = $clog2(TOKEN_MAX + 3);
	localparam int XW         = (TW > btp_pkg::TOKIN_W) ? TW : btp_pkg::TOKIN_W;
	localparam int W_RANGE    = (TOKEN_MAX >> 6) - (TOKEN_MIN >> 6) + 1;
	localparam int CW         = $clog2(W_RANGE + 1);
	localparam logic [AW-1:0] MIN_WORD  = AW'(TOKEN_MIN >> 6);
	localparam logic [AW-1:0] MAX_WORD  = AW'(TOKEN_MAX >> 6);
	localparam logic [AW-1:0] LAST_ADDR = AW'(POOL_WORDS - 1);

	localparam int WW = btp_pkg::WORD_W;
	localparam int BW = btp_pkg::BIT_W;

	// request context
	logic [btp_pkg::REQ_W-1:0]    op_q;
	logic                         tin_ok_q;
	logic [BW-1:0]                bit_q;
	logic [AW-1:0]                wrd_q;
	logic [XW-1:0]                start_q;
	logic                         first_q;
	logic [CW-1:0]                left_q;
	logic [XW-1:0]                ptr_q;
	logic [AW-1:0]                clr_q;

	// finished result and output register
	logic [btp_pkg::TOKOUT_W-1:0] res_tok_q;
	logic                         res_live_q;
	logic                         out_valid_q;
	logic [btp_pkg::TOKOUT_W-1:0] out_tok_q;
	logic                         out_live_q;

	// RAM ports
	logic          ram_we;
	logic [AW-1:0] ram_waddr;
	logic [WW-1:0] ram_wdata;
	logic          ram_re;
	logic [AW-1:0] ram_raddr;
	logic [WW-1:0] rdata;

	logic [XW-1:0]    tin_x;
	logic             tin_ok;
	logic [XW-1:0]    start_tok;
	logic [AW-1:0]    next_wrd;
	logic [31:0]      tok_base;
	logic [WW-1:0]    scan_mask;
	logic [WW-1:0]    free_bits;
	btp_pkg::ffs_t    pick;
	logic             is_birth;
	logic             found;
	logic             done;
	logic [XW-1:0]    found_tok;

	// incoming token and pointer wrap
	assign tin_x     = XW'(token_in);
	assign tin_ok    = (32'(token_in) >= 32'(TOKEN_MIN)) && (32'(token_in) <= 32'(TOKEN_MAX));
	assign start_tok = (32'(ptr_q) > 32'(TOKEN_MAX)) ? XW'(TOKEN_MIN) : ptr_q;

	// cyclic word order over the words that hold pool tokens
	assign next_wrd = (wrd_q == MAX_WORD) ? MIN_WORD : wrd_q + AW'(1);

	// free-token search in the current word
	assign tok_base = 32'(wrd_q) << 6;
	always_comb begin
		for (int i = 0; i < WW; i++) begin
			scan_mask[i] = ((tok_base + 32'(i)) >= 32'(TOKEN_MIN))
				&& ((tok_base + 32'(i)) <= 32'(TOKEN_MAX))
				&& (!first_q || (BW'(i) >= start_q[BW-1:0]));
		end
	end
	assign free_bits = ~rdata & scan_mask;
	assign pick      = btp_pkg::ffs64(free_bits);
	assign is_birth  = (op_q == btp_pkg::REQ_BIRTH);
	assign found     = is_birth && pick.found;
	assign done      = !is_birth || found || (left_q == '0);
	assign found_tok = XW'({wrd_q, pick.idx});

	// status
	assign sts.clr_last = (clr_q == LAST_ADDR);
	assign sts.done     = done;
	assign sts.out_busy = out_valid_q && !rsp_ready;

	// RAM access: clearing pass, birth mark, kill clear
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = wrd_q;
		ram_wdata = rdata;
		if (cmd.clear) begin
			ram_we    = 1'b1;
			ram_waddr = clr_q;
			ram_wdata = '0;
		end else if (cmd.eval) begin
			case (op_q)
				btp_pkg::REQ_BIRTH: begin
					ram_we    = found;
					ram_wdata = rdata | (WW'(1) << pick.idx);
				end
				btp_pkg::REQ_KILL: begin
					ram_we    = tin_ok_q;
					ram_wdata = rdata & ~(WW'(1) << bit_q);
				end
				default: ram_we = 1'b0;
			endcase
		end
	end

	assign ram_re    = cmd.load || cmd.eval;
	assign ram_raddr = cmd.load
		? ((req_type == btp_pkg::REQ_BIRTH) ? start_tok[BW +: AW] : tin_x[BW +: AW])
		: next_wrd;

	btp_ram #(
		.WIDTH (WW),
		.DEPTH (POOL_WORDS)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (rdata)
	);

	// request context and scan stepping
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q     <= req_type;
			tin_ok_q <= tin_ok;
			bit_q    <= tin_x[BW-1:0];
			start_q  <= start_tok;
			first_q  <= 1'b1;
			left_q   <= CW'(W_RANGE);
			wrd_q    <= (req_type == btp_pkg::REQ_BIRTH) ? start_tok[BW +: AW]
				: tin_x[BW +: AW];
		end else if (cmd.eval) begin
			if (done) begin
				res_tok_q  <= found ? found_tok[btp_pkg::TOKOUT_W-1:0] : '0;
				res_live_q <= (op_q == btp_pkg::REQ_QUERY) && tin_ok_q && rdata[bit_q];
			end else begin
				wrd_q   <= next_wrd;
				first_q <= 1'b0;
				left_q  <= left_q - CW'(1);
			end
		end
	end

	// next-fit pointer and clearing counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ptr_q <= XW'(TOKEN_MIN);
			clr_q <= '0;
		end else begin
			if (cmd.clear) begin
				clr_q <= clr_q + AW'(1);
			end
			if (cmd.eval && done && is_birth) begin
				ptr_q <= found ? found_tok + XW'(1) : start_q + XW'(2);
			end
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.push) begin
			out_valid_q <= 1'b1;
		end else if (rsp_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.push) begin
			out_tok_q  <= res_tok_q;
			out_live_q <= res_live_q;
		end
	end

	assign rsp_valid = out_valid_q;
	assign token_out = out_tok_q;
	assign is_live   = out_live_q;

endmodule
`default_nettype wire

@@ design/bitmap_token_pool_top.sv @@
`default_nettype none
// ---------------------------------------------------------------------------
// bitmap_token_pool_top: next-fit token allocator over a live bitmap
// Kill and query each read one bitmap word, and a kill writes it back.
// Birth scans from the pointer's word over the W words holding pool tokens
// (16 by default), one word per cycle through the single read port.
// The result passes a result register, then the output register; a new request
// is taken while it waits there. After reset a clearing pass zeroes all
// (TOKEN_MAX/64)+1 bitmap words before the first request is accepted.
// ---------------------------------------------------------------------------
module bitmap_token_pool_top #(
	parameter int TOKEN_MAX = 1023,
	parameter int TOKEN_MIN = 16
) (
	input wire logic clk,
	input wire logic arst_n,
	btp_req_if.sink  req,
	btp_rsp_if.source rsp
);

	btp_pkg::btp_cmd_t cmd;
	btp_pkg::btp_sts_t sts;

	// sequencer
	btp_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_ready (req.ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	// bitmap, pointer and output register
	btp_dpath #(
		.TOKEN_MAX (TOKEN_MAX),
		.TOKEN_MIN (TOKEN_MIN)
	) u_dpath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.sts       (sts),
		.req_type  (req.req_type),
		.token_in  (req.token_in),
		.rsp_valid (rsp.valid),
		.rsp_ready (rsp.ready),
		.token_out (rsp.token_out),
		.is_live   (rsp.is_live)
	);

endmodule
`default_nettype wire

@@ tb/sv/tb.sv @@
// ---------------------------------------------------------------------------
// tb: self-checking bench for the bitmap token pool
// Drives birth, kill and query requests over the request channel and checks
// every response against a cycle-free model of the live bitmap and the
// next-fit pointer. A directed table covers reset state, range edges, double
// kills, ignored codes and next-fit order; random phases then fill the pool
// to exhaustion, churn near full and drain it, with random idling on both
// channels and one long response hold-off.
// ---------------------------------------------------------------------------
module tb;

	localparam int POOL_MIN   = 16;
	localparam int POOL_MAX   = 1023;
	localparam int POOL_SPAN  = POOL_MAX - POOL_MIN + 1;
	localparam int POOL_WORDS = (POOL_MAX / btp_pkg::WORD_W) + 1;

	// code that the block answers with a zero response and no bitmap change
	localparam logic [btp_pkg::REQ_W-1:0] REQ_NONE = 2'd3;

	// run limit over all phases, with a wide margin
	localparam int CYCLE_LIMIT = 1000000;
	// longest birth scan plus output stage, with margin
	localparam int DRAIN_CYCLES = 40;
	localparam int DIR_ROWS     = 25;

	typedef struct packed {
		logic [btp_pkg::TOKOUT_W-1:0] tok;
		logic                         live;
	} rsp_exp_t;

	typedef struct packed {
		logic [btp_pkg::REQ_W-1:0]    rq;
		logic [btp_pkg::TOKIN_W-1:0]  tok;
		logic                         fixed;
		logic [btp_pkg::TOKOUT_W-1:0] x_tok;
		logic                         x_live;
	} dir_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	btp_req_if req_if();
	btp_rsp_if rsp_if();

	bitmap_token_pool_top #(
		.TOKEN_MAX(POOL_MAX),
		.TOKEN_MIN(POOL_MIN)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.req(req_if),
		.rsp(rsp_if)
	);

	// model state of the pool
	logic [btp_pkg::WORD_W-1:0] live_map [POOL_WORDS];
	logic [10:0]                next_ptr;
	int                         live_cnt;

	// typed-in expectation that travels with the driven request
	logic                         drv_fixed = 1'b0;
	logic [btp_pkg::TOKOUT_W-1:0] drv_tok = '0;
	logic                         drv_live = 1'b0;

	rsp_exp_t rsp_expq [$];
	dir_row_t dir_tbl [DIR_ROWS];
	int       err_cnt = 0;
	int       rsp_seen = 0;
	int       cyc_cnt = 0;
	int       snd_burst = 0;

	// clock
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// run limit
	always @(posedge clk) begin
		cyc_cnt <= cyc_cnt + 1;
		if (cyc_cnt >= CYCLE_LIMIT) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	function automatic logic in_pool(input int t);
		return t >= POOL_MIN && t <= POOL_MAX;
	endfunction

	function automatic logic tok_live(input int t);
		return live_map[t / btp_pkg::WORD_W][t % btp_pkg::WORD_W];
	endfunction

	// next-fit scan: claims the first free token from the pointer on
	function automatic logic [btp_pkg::TOKOUT_W-1:0] pool_birth();
		logic [10:0] cand;
		int          tries;
		cand = next_ptr;
		next_ptr = next_ptr + 11'd1;
		for (tries = 0; tries <= POOL_SPAN; tries++) begin
			if (!in_pool(int'(cand))) begin
				cand = 11'(POOL_MIN);
				next_ptr = 11'(POOL_MIN + 1);
			end
			if (!tok_live(int'(cand))) begin
				live_map[cand / btp_pkg::WORD_W][cand % btp_pkg::WORD_W] = 1'b1;
				live_cnt++;
				return cand[btp_pkg::TOKOUT_W-1:0];
			end
			cand = next_ptr;
			next_ptr = next_ptr + 11'd1;
		end
		return '0;
	endfunction

	// applies one request to the model and gives its response
	task automatic pool_apply(input logic [btp_pkg::REQ_W-1:0] rq,
			input logic [btp_pkg::TOKIN_W-1:0] tk,
			output logic [btp_pkg::TOKOUT_W-1:0] tok_o, output logic live_o);
		int t;
		t = int'(tk);
		tok_o = '0;
		live_o = 1'b0;
		case (rq)
			btp_pkg::REQ_BIRTH: begin
				tok_o = pool_birth();
			end
			btp_pkg::REQ_KILL: begin
				if (in_pool(t) && tok_live(t)) begin
					live_map[t / btp_pkg::WORD_W][t % btp_pkg::WORD_W] = 1'b0;
					live_cnt--;
				end
			end
			btp_pkg::REQ_QUERY: begin
				if (in_pool(t)) begin
					live_o = tok_live(t);
				end
			end
			default: begin
			end
		endcase
	endtask

	// response check, then capture of the request accepted at this edge
	always @(posedge clk) begin : score
		rsp_exp_t                     want;
		logic [btp_pkg::TOKOUT_W-1:0] p_tok;
		logic                         p_live;
		if (rsp_if.valid && rsp_if.ready) begin
			rsp_seen++;
			if (rsp_expq.size() == 0) begin
				$error("response with nothing pending: token_out=%0d is_live=%0d",
					rsp_if.token_out, rsp_if.is_live);
				err_cnt++;
			end else begin
				want = rsp_expq.pop_front();
				if (rsp_if.token_out !== want.tok) begin
					$error("token_out: expected %0d, actual %0d", want.tok, rsp_if.token_out);
					err_cnt++;
				end
				if (rsp_if.is_live !== want.live) begin
					$error("is_live: expected %0d, actual %0d", want.live, rsp_if.is_live);
					err_cnt++;
				end
			end
		end
		if (arst_n && req_if.valid && req_if.ready) begin
			pool_apply(req_if.req_type, req_if.token_in, p_tok, p_live);
			if (drv_fixed) begin
				p_tok = drv_tok;
				p_live = drv_live;
			end
			want.tok = p_tok;
			want.live = p_live;
			rsp_expq.push_back(want);
		end
	end

	// sender idle length: mostly none or short, a few long, some gapless runs
	function automatic int pick_gap();
		int r;
		if (snd_burst > 0) begin
			snd_burst--;
			return 0;
		end
		r = $urandom_range(0, 63);
		if (r == 0) begin
			snd_burst = $urandom_range(20, 60);
			return 0;
		end
		if (r < 32) begin
			return 0;
		end
		if (r < 58) begin
			return $urandom_range(1, 3);
		end
		return $urandom_range(10, 50);
	endfunction

	// token for kill or query: live ones, pool range, range edges, raw bits
	function automatic logic [btp_pkg::TOKIN_W-1:0] pick_token();
		int r;
		int t;
		int k;
		r = $urandom_range(0, 99);
		if (r < 40) begin
			t = $urandom_range(POOL_MIN, POOL_MAX);
			for (k = 0; k < 8 && !tok_live(t); k++) begin
				t = $urandom_range(POOL_MIN, POOL_MAX);
			end
		end else if (r < 75) begin
			t = $urandom_range(POOL_MIN, POOL_MAX);
		end else if (r < 85) begin
			case ($urandom_range(0, 5))
				0: t = 0;
				1: t = POOL_MIN - 1;
				2: t = POOL_MIN;
				3: t = POOL_MAX;
				4: t = POOL_MAX + 1;
				default: t = (1 << btp_pkg::TOKIN_W) - 1;
			endcase
		end else begin
			t = $urandom_range(0, (1 << btp_pkg::TOKIN_W) - 1);
		end
		return btp_pkg::TOKIN_W'(t);
	endfunction

	// one request transfer, then an optional idle stretch
	task automatic send_req(input logic [btp_pkg::REQ_W-1:0] rq,
			input logic [btp_pkg::TOKIN_W-1:0] tk, input logic fx,
			input logic [btp_pkg::TOKOUT_W-1:0] ftok, input logic flive);
		int gap;
		req_if.valid <= 1'b1;
		req_if.req_type <= rq;
		req_if.token_in <= tk;
		drv_fixed <= fx;
		drv_tok <= ftok;
		drv_live <= flive;
		do begin
			@(posedge clk);
		end while (!req_if.ready);
		gap = pick_gap();
		if (gap > 0) begin
			req_if.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic send_random(input int wb, input int wk, input int wq);
		int r;
		r = $urandom_range(0, 99);
		if (r < wb) begin
			send_req(btp_pkg::REQ_BIRTH, btp_pkg::TOKIN_W'($urandom), 1'b0, '0, 1'b0);
		end else if (r < wb + wk) begin
			send_req(btp_pkg::REQ_KILL, pick_token(), 1'b0, '0, 1'b0);
		end else if (r < wb + wk + wq) begin
			send_req(btp_pkg::REQ_QUERY, pick_token(), 1'b0, '0, 1'b0);
		end else begin
			send_req(REQ_NONE, btp_pkg::TOKIN_W'($urandom), 1'b0, '0, 1'b0);
		end
	endtask

	// sender pauses until every pending response has come back
	task automatic wait_idle();
		req_if.valid <= 1'b0;
		@(posedge clk);
		while (rsp_expq.size() != 0) begin
			@(posedge clk);
		end
	endtask

	// response side: random ready, long open stretches, one long hold-off
	initial begin : sink
		int  on_len;
		int  off_len;
		int  r;
		logic held;
		held = 1'b0;
		rsp_if.ready <= 1'b0;
		@(posedge clk);
		forever begin
			r = $urandom_range(0, 31);
			on_len = (r == 0) ? $urandom_range(100, 300) : $urandom_range(1, 8);
			rsp_if.ready <= 1'b1;
			repeat (on_len) @(posedge clk);
			if (!held && rsp_seen >= 200) begin
				off_len = 400;
				held = 1'b1;
			end else begin
				r = $urandom_range(0, 15);
				if (r < 8) begin
					off_len = 0;
				end else if (r < 15) begin
					off_len = $urandom_range(1, 3);
				end else begin
					off_len = $urandom_range(10, 50);
				end
			end
			if (off_len > 0) begin
				rsp_if.ready <= 1'b0;
				repeat (off_len) @(posedge clk);
			end
		end
	end

	// stimulus
	initial begin : stim
		int i;
		int n_free;
		int n_born;
		for (i = 0; i < POOL_WORDS; i++) begin
			live_map[i] = '0;
		end
		next_ptr = 11'(POOL_MIN);
		live_cnt = 0;
		req_if.valid <= 1'b0;
		req_if.req_type <= btp_pkg::REQ_BIRTH;
		req_if.token_in <= '0;

		dir_tbl = '{
			'{btp_pkg::REQ_QUERY, 12'd16,   1'b1, 10'd0,  1'b0},  // nothing live after reset
			'{btp_pkg::REQ_BIRTH, 12'd0,    1'b1, 10'd16, 1'b0},  // first token is the floor
			'{btp_pkg::REQ_BIRTH, 12'd4095, 1'b1, 10'd17, 1'b0},  // token_in ignored on birth
			'{btp_pkg::REQ_QUERY, 12'd16,   1'b1, 10'd0,  1'b1},
			'{btp_pkg::REQ_QUERY, 12'd17,   1'b0, 10'd0,  1'b0},
			'{btp_pkg::REQ_QUERY, 12'd18,   1'b1, 10'd0,  1'b0},
			'{btp_pkg::REQ_QUERY, 12'd15,   1'b1, 10'd0,  1'b0},  // below range
			'{btp_pkg::REQ_QUERY, 12'd0,    1'b1, 10'd0,  1'b0},
			'{btp_pkg::REQ_QUERY, 12'd1023, 1'b1, 10'd0,  1'b0},
			'{btp_pkg::REQ_QUERY, 12'd1024, 1'b1, 10'd0,  1'b0},  // above range
			'{btp_pkg::REQ_QUERY, 12'd4095, 1'b1, 10'd0,  1'b0},
			'{btp_pkg::REQ_KILL,  12'd4095, 1'b1, 10'd0,  1'b0},  // out of range kill ignored
			'{btp_pkg::REQ_KILL,  12'd15,   1'b1, 10'd0,  1'b0},
			'{btp_pkg::REQ_KILL,  12'd16,   1'b1, 10'd0,  1'b0},
			'{btp_pkg::REQ_QUERY, 12'd16,   1'b1, 10'd0,  1'b0},
			'{btp_pkg::REQ_BIRTH, 12'd0,    1'b1, 10'd18, 1'b0},  // next-fit skips freed 16
			'{REQ_NONE,           12'd16,   1'b1, 10'd0,  1'b0},
			'{REQ_NONE,           12'd4095, 1'b1, 10'd0,  1'b0},
			'{btp_pkg::REQ_QUERY, 12'd16,   1'b1, 10'd0,  1'b0},
			'{btp_pkg::REQ_KILL,  12'd17,   1'b1, 10'd0,  1'b0},
			'{btp_pkg::REQ_KILL,  12'd17,   1'b1, 10'd0,  1'b0},  // kill of a free token
			'{btp_pkg::REQ_QUERY, 12'd17,   1'b1, 10'd0,  1'b0},
			'{btp_pkg::REQ_BIRTH, 12'd2730, 1'b0, 10'd0,  1'b0},
			'{btp_pkg::REQ_KILL,  12'd1023, 1'b0, 10'd0,  1'b0},
			'{btp_pkg::REQ_QUERY, 12'd2048, 1'b1, 10'd0,  1'b0}
		};

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		// directed rows
		for (i = 0; i < DIR_ROWS; i++) begin
			send_req(dir_tbl[i].rq, dir_tbl[i].tok, dir_tbl[i].fixed,
				dir_tbl[i].x_tok, dir_tbl[i].x_live);
		end

		// mixed traffic, long response hold-off lands here
		for (i = 0; i < 500; i++) begin
			send_random(45, 25, 25);
		end

		// fill the pool, then keep asking past exhaustion
		wait_idle();
		n_free = POOL_SPAN - live_cnt;
		n_born = 0;
		while (n_born < n_free + 16) begin
			if ($urandom_range(0, 9) == 0) begin
				send_req(btp_pkg::REQ_QUERY, pick_token(), 1'b0, '0, 1'b0);
			end else begin
				send_req(btp_pkg::REQ_BIRTH, btp_pkg::TOKIN_W'($urandom), 1'b0, '0, 1'b0);
				n_born++;
			end
		end

		// churn near full: long scans and pointer wraps
		for (i = 0; i < 260; i++) begin
			send_random(40, 40, 15);
		end

		// drain
		wait_idle();
		for (i = 0; i < 150; i++) begin
			send_random(20, 60, 18);
		end

		wait_idle();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (err_cnt == 0 && rsp_expq.size() == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

endmodule
